>>> design/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue.
// No dependencies; compiled first.
package spq_pkg;

  // Operation codes carried in the request opcode field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // qualified insert: queue not full
    logic pop;  // qualified pop: queue not empty
  } spq_cell_ctrl_t;

endpackage

>>> design/spq_if.sv
// spq_req_if / spq_rsp_if: valid/ready channels of the sorted priority queue.
// Stand-alone; no package needed.
interface spq_req_if #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8
);
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;

  modport source (output valid, output opcode, output key, output tag, input ready);
  modport sink   (input valid, input opcode, input key, input tag, output ready);
endinterface

interface spq_rsp_if #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8,
  parameter int CNT_BITS = 5
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic [CNT_BITS-1:0] count;

  modport source (output valid, output status, output out_key, output out_tag,
                  output count, input ready);
  modport sink   (input valid, input status, input out_key, input out_tag,
                  input count, output ready);
endinterface

>>> design/sorted_priority_queue.sv
// sorted_priority_queue: bounded max-first priority queue built as a chain of cells.
// Depends on spq_pkg, spq_if.sv (request/response channels) and spq_cell.
//
//  Channel | Dir | Payload                           | Transfer
//  --------+-----+-----------------------------------+--------------------------
//  req     | in  | opcode, key, tag                  | req.valid && req.ready
//  rsp     | out | status, out_key, out_tag, count   | rsp.valid && rsp.ready
//
// Operation: every cell compares against the broadcast key in parallel and
//   moves its entry in the same edge, so back-to-back requests are taken as
//   the responses drain. A cell looks only at its own compare and its head-side
//   neighbor's, so one compare plus a mux sets the cycle, independent of DEPTH.
// Latency: the response appears in the response register the cycle after
//   the request transfer.
// Stalls: a request is taken while the response register is empty or being
//   drained in the same cycle.
// Reset: synchronous; clears cell valid bits, the count and response valid.
module sorted_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  // chain taps
  logic [KEY_BITS-1:0] cell_key   [DEPTH];
  logic [TAG_BITS-1:0] cell_tag   [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_ge;

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;

  // response register
  logic                res_valid;
  logic [1:0]          res_status;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CNT_BITS-1:0] res_count;

  logic           fire;
  logic           is_pop;
  logic           full;
  logic           empty;
  spq_cell_ctrl_t ctrl;

  assign req.ready = !res_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign is_pop    = (req.opcode == OP_POP);
  assign full      = (count == CNT_BITS'(DEPTH));
  assign empty     = (count == '0);

  // rejected operations leave the chain untouched
  assign ctrl.ins = fire && !is_pop && !full;
  assign ctrl.pop = fire && is_pop && !empty;

  // Cell 0 sees a virtual head that always ranks ahead; the last cell sees
  // an empty slot behind it, so a pop clears the tail.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_BITS-1:0] p_key;
      logic [TAG_BITS-1:0] p_tag;
      logic                p_valid;
      logic                p_ge;
      logic [KEY_BITS-1:0] n_key;
      logic [TAG_BITS-1:0] n_tag;
      logic                n_valid;

      if (gi == 0) begin : g_head
        assign p_key   = '0;
        assign p_tag   = '0;
        assign p_valid = 1'b0;
        assign p_ge    = 1'b1;
      end else begin : g_mid
        assign p_key   = cell_key[gi-1];
        assign p_tag   = cell_tag[gi-1];
        assign p_valid = cell_valid[gi-1];
        assign p_ge    = cell_ge[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign n_key   = '0;
        assign n_tag   = '0;
        assign n_valid = 1'b0;
      end else begin : g_body
        assign n_key   = cell_key[gi+1];
        assign n_tag   = cell_tag[gi+1];
        assign n_valid = cell_valid[gi+1];
      end

      spq_cell #(
        .KEY_BITS(KEY_BITS),
        .TAG_BITS(TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .ins_key   (req.key),
        .ins_tag   (req.tag),
        .prev_key  (p_key),
        .prev_tag  (p_tag),
        .prev_valid(p_valid),
        .prev_ge   (p_ge),
        .next_key  (n_key),
        .next_tag  (n_tag),
        .next_valid(n_valid),
        .key       (cell_key[gi]),
        .tag       (cell_tag[gi]),
        .valid     (cell_valid[gi]),
        .ge        (cell_ge[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_BITS'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // response payload; head of chain is the largest entry
  always_ff @(posedge clk) begin
    if (fire) begin
      res_count <= count_next;
      res_key   <= '0;
      res_tag   <= '0;
      res_status <= ST_OK;
      if (is_pop) begin
        if (empty) begin
          res_status <= ST_EMPTY;
        end else begin
          res_key <= cell_key[0];
          res_tag <= cell_tag[0];
        end
      end else if (full) begin
        res_status <= ST_FULL;
      end
    end
  end

  assign rsp.valid   = res_valid;
  assign rsp.status  = res_status;
  assign rsp.out_key = res_key;
  assign rsp.out_tag = res_tag;
  assign rsp.count   = res_count;

`ifndef SYNTHESIS
  // occupancy bits track the count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with count");

  // occupied cells form a contiguous run from the head
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + DEPTH'(1))) == '0)
    else $error("gap in occupied cells");

  // a successful pop lowers the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> count == $past(count) - CNT_BITS'(1))
    else $error("count not decremented on pop");

  // neighboring occupied cells stay in non-increasing key order
  generate
    for (gi = 0; gi < DEPTH - 1; gi++) begin : g_order_chk
      a_order: assert property (@(posedge clk) disable iff (rst)
        cell_valid[gi+1] |-> cell_key[gi] >= cell_key[gi+1])
        else $error("chain out of order");
    end
  endgenerate
`endif

endmodule

>>> design/spq_cell.sv
// spq_cell: one slot of the sorted chain; holds a key, a tag and a valid bit.
// Depends on spq_pkg for the cell command struct.
module spq_cell #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  spq_pkg::spq_cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]    ins_key,
  input  logic [TAG_BITS-1:0]    ins_tag,
  // neighbor toward the head (larger keys)
  input  logic [KEY_BITS-1:0]    prev_key,
  input  logic [TAG_BITS-1:0]    prev_tag,
  input  logic                   prev_valid,
  input  logic                   prev_ge,
  // neighbor toward the tail (smaller keys)
  input  logic [KEY_BITS-1:0]    next_key,
  input  logic [TAG_BITS-1:0]    next_tag,
  input  logic                   next_valid,
  output logic [KEY_BITS-1:0]    key,
  output logic [TAG_BITS-1:0]    tag,
  output logic                   valid,
  output logic                   ge
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0] key_next;
  logic [TAG_BITS-1:0] tag_next;
  logic                valid_next;

  // entry stays ahead of the incoming key (ties keep arrival order)
  assign ge = valid && (key >= ins_key);

  always_comb begin
    key_next   = key;
    tag_next   = tag;
    valid_next = valid;
    if (ctrl.ins) begin
      if (!ge) begin
        if (prev_ge) begin
          // insertion point
          key_next   = ins_key;
          tag_next   = ins_tag;
          valid_next = 1'b1;
        end else begin
          // shift down by one
          key_next   = prev_key;
          tag_next   = prev_tag;
          valid_next = prev_valid;
        end
      end
    end else if (ctrl.pop) begin
      key_next   = next_key;
      tag_next   = next_tag;
      valid_next = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule
